// ===== hw/rtl/rrst_pkg.sv =====
// shared types and constants for the repeat report suppression table
// used by rrst_table and repeat_report_suppression_table
`default_nettype none

package rrst_pkg;

  localparam int TABLE_ENTRIES = 24;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam int HASH_W = 32;
  localparam int RSSI_W = 8;
  localparam int TIME_W = 32;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [RSSI_W-1:0] RSSI_FLOOR_RESET = -8'sd80;
  localparam logic [TIME_W-1:0] HOLD_OFF_RESET = 32'd10000;

  localparam logic [CFG_IDX_W-1:0] CFG_RSSI_FLOOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_OFF   = 1'd1;

  typedef enum logic [1:0] {
    OUTCOME_TOO_WEAK   = 2'd0,
    OUTCOME_SUPPRESSED = 2'd1,
    OUTCOME_REFRESHED  = 2'd2,
    OUTCOME_PLACED     = 2'd3
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PLACE,
    ST_EMIT
  } state_t;

  // write request into the table
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic              key_en;
    logic [HASH_W-1:0] key;
    logic [TIME_W-1:0] stamp;
  } tbl_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rrst_table.sv =====
// key and stamp storage, one read port at the scan index, one write port
// depends on rrst_pkg
`default_nettype none

module rrst_table (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [rrst_pkg::IDX_W-1:0]   rd_idx,
  input  wire rrst_pkg::tbl_wr_t            wr,
  output logic      [rrst_pkg::HASH_W-1:0]  rd_key,
  output logic      [rrst_pkg::TIME_W-1:0]  rd_stamp
);

  logic [rrst_pkg::HASH_W-1:0] keys   [rrst_pkg::TABLE_ENTRIES];
  logic [rrst_pkg::TIME_W-1:0] stamps [rrst_pkg::TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rrst_pkg::TABLE_ENTRIES; i++) begin
        keys[i]   <= '0;
        stamps[i] <= '0;
      end
    end else if (wr.en) begin
      stamps[wr.idx] <= wr.stamp;
      if (wr.key_en) begin
        keys[wr.idx] <= wr.key;
      end
    end
  end

  assign rd_key   = keys[rd_idx];
  assign rd_stamp = stamps[rd_idx];

endmodule

`default_nettype wire

// ===== hw/rtl/repeat_report_suppression_table.sv =====
// an item below the strength floor skips the scan and goes straight to its result;
// any other item scans the table one entry a cycle, ending early on a key match,
// else going on to place the item in an empty entry or, failing that, the oldest one
// the scan of the single table read port sets the rate: one item at a time, the next
// request taken once the result is loaded into the output register
// reset clears the table to zero and loads rssi_floor -80, hold_off_ms 10000
// depends on rrst_pkg and rrst_table
`default_nettype none

module repeat_report_suppression_table (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // s_tdata: device_hash[31:0], signal_strength[39:32], time_ms[71:40]
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [rrst_pkg::IN_DATA_W-1:0]    s_tdata,
  // m_tdata: forward[0], outcome[2:1], zero[7:3]
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [rrst_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rrst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rrst_pkg::CFG_DATA_W-1:0]   cfg_data
);

  rrst_pkg::state_t state, state_next;

  logic signed [rrst_pkg::RSSI_W-1:0] rssi_floor;
  logic        [rrst_pkg::TIME_W-1:0] hold_off_ms;

  logic [rrst_pkg::HASH_W-1:0] hash_q;
  logic [rrst_pkg::TIME_W-1:0] time_q;
  logic [rrst_pkg::IDX_W-1:0]  scan_idx;
  logic                        empty_found;
  logic [rrst_pkg::IDX_W-1:0]  empty_idx;
  logic [rrst_pkg::IDX_W-1:0]  oldest_idx;
  logic [rrst_pkg::TIME_W-1:0] oldest_stamp;
  logic                        res_forward;
  rrst_pkg::outcome_t          res_outcome;

  logic [rrst_pkg::HASH_W-1:0] rd_key;
  logic [rrst_pkg::TIME_W-1:0] rd_stamp;
  rrst_pkg::tbl_wr_t           wr;

  logic signed [rrst_pkg::RSSI_W-1:0] in_rssi;
  logic                        in_weak;
  logic                        hit;
  logic [rrst_pkg::TIME_W-1:0] elapsed;
  logic                        suppress;
  logic                        last;
  logic                        out_free;
  logic [rrst_pkg::IDX_W-1:0]  place_idx;

  assign in_rssi  = s_tdata[39:32];
  assign in_weak  = in_rssi < rssi_floor;
  assign hit      = rd_key == hash_q;
  assign elapsed  = time_q - rd_stamp;
  assign suppress = elapsed < hold_off_ms;
  assign last     = scan_idx == rrst_pkg::IDX_W'(rrst_pkg::TABLE_ENTRIES - 1);
  assign out_free = !m_tvalid || m_tready;
  assign place_idx = empty_found ? empty_idx : oldest_idx;
  assign cfg_ready = 1'b1;

  rrst_table u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_idx   (scan_idx),
    .wr       (wr),
    .rd_key   (rd_key),
    .rd_stamp (rd_stamp)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rrst_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = in_weak ? rrst_pkg::ST_EMIT : rrst_pkg::ST_SCAN;
        end
      end
      rrst_pkg::ST_SCAN: begin
        if (hit) begin
          state_next = rrst_pkg::ST_EMIT;
        end else if (last) begin
          state_next = rrst_pkg::ST_PLACE;
        end
      end
      rrst_pkg::ST_PLACE: state_next = rrst_pkg::ST_EMIT;
      rrst_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = rrst_pkg::ST_IDLE;
        end
      end
      default: state_next = rrst_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_tready  = 1'b0;
    wr.en     = 1'b0;
    wr.idx    = scan_idx;
    wr.key_en = 1'b0;
    wr.key    = hash_q;
    wr.stamp  = time_q;
    unique case (state)
      rrst_pkg::ST_IDLE:  s_tready = 1'b1;
      rrst_pkg::ST_SCAN:  wr.en = hit && !suppress;
      rrst_pkg::ST_PLACE: begin
        wr.en     = 1'b1;
        wr.key_en = 1'b1;
        wr.idx    = place_idx;
      end
      rrst_pkg::ST_EMIT:  s_tready = 1'b0;
      default:            s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rrst_pkg::ST_IDLE;
      rssi_floor  <= rrst_pkg::RSSI_FLOOR_RESET;
      hold_off_ms <= rrst_pkg::HOLD_OFF_RESET;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        if (cfg_index == rrst_pkg::CFG_RSSI_FLOOR) begin
          rssi_floor <= cfg_data[rrst_pkg::RSSI_W-1:0];
        end else if (cfg_index == rrst_pkg::CFG_HOLD_OFF) begin
          hold_off_ms <= cfg_data[rrst_pkg::TIME_W-1:0];
        end
      end
      if (state == rrst_pkg::ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      rrst_pkg::ST_IDLE: begin
        hash_q      <= s_tdata[31:0];
        time_q      <= s_tdata[71:40];
        scan_idx    <= '0;
        empty_found <= 1'b0;
        res_forward <= 1'b0;
        res_outcome <= rrst_pkg::OUTCOME_TOO_WEAK;
      end
      rrst_pkg::ST_SCAN: begin
        if (hit) begin
          res_forward <= !suppress;
          res_outcome <= suppress ? rrst_pkg::OUTCOME_SUPPRESSED
                                  : rrst_pkg::OUTCOME_REFRESHED;
        end
        if (rd_key == '0 && !empty_found) begin
          empty_found <= 1'b1;
          empty_idx   <= scan_idx;
        end
        // strict compare keeps the lowest index on ties
        if (scan_idx == '0 || rd_stamp < oldest_stamp) begin
          oldest_idx   <= scan_idx;
          oldest_stamp <= rd_stamp;
        end
        scan_idx <= scan_idx + 1'b1;
      end
      rrst_pkg::ST_PLACE: begin
        res_forward <= 1'b1;
        res_outcome <= rrst_pkg::OUTCOME_PLACED;
      end
      rrst_pkg::ST_EMIT: begin
        if (out_free) begin
          m_tdata <= {5'd0, res_outcome, res_forward};
        end
      end
      default: res_forward <= 1'b0;
    endcase
  end

endmodule

`default_nettype wire
